// ----- rtl/sots_pkg.sv -----
// Shared types and constants for the sum-of-two-squares block.
package sots_pkg;

  localparam int FIELD_W = 64;  // width of an input field
  localparam int ROOT_W  = 32;  // width of an output root

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CHECK_W,
    ST_DIV,
    ST_FIN_A,
    ST_FIN_B,
    ST_OUT
  } sots_state_e;

endpackage

// ----- rtl/sots_in_if.sv -----
// Input channel: value p and root t, valid/ready handshake.
interface sots_in_if import sots_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] prime_value;
  logic [FIELD_W-1:0] root_of_minus_one;

  modport source (output valid, prime_value, root_of_minus_one, input ready);
  modport sink   (input valid, prime_value, root_of_minus_one, output ready);
endinterface

// ----- rtl/sots_out_if.sv -----
// Output channel: the two roots and the not-found flag, valid/ready handshake.
interface sots_out_if import sots_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] first_root;
  logic [ROOT_W-1:0] second_root;
  logic              not_found;

  modport source (output valid, first_root, second_root, not_found, input ready);
  modport sink   (input valid, first_root, second_root, not_found, output ready);
endinterface

// ----- rtl/sots_divider.sv -----
// Restoring remainder unit, one quotient bit per cycle.
module sots_divider import sots_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvd_q;
  logic [WIDTH-1:0] dsr_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;

  always_comb begin
    shifted = {rem_q, dvd_q[WIDTH-1]};
    trial   = shifted - {1'b0, dsr_q};
    // remainder stays below the divisor, so the top bit drops out either way
    if (shifted >= {1'b0, dsr_q}) begin
      rem_d = trial[WIDTH-1:0];
    end else begin
      rem_d = shifted[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/sots_square.sv -----
// Registered squarer for half-width operands.
module sots_square import sots_pkg::*; #(
  parameter int HW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [HW-1:0]   x_i,
  output logic [2*HW-1:0] sq_o
);

  logic [2*HW-1:0] sq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= (2*HW)'(x_i) * (2*HW)'(x_i);
    end
  end

  assign sq_o = sq_q;

endmodule

// ----- rtl/sum_of_two_squares_from_root.sv -----
// Top level: splits p into a sum of two squares from a root of -1 modulo p.
//
//  channel  dir  payload                                   accepted when
//  in_i     in   prime_value, root_of_minus_one (64 b)     valid && ready
//  out_o    out  first_root, second_root (32 b), not_found valid && ready
//
// One item at a time. Each Euclid step runs the bit-serial remainder unit and
// then the loop test on the squarer (the squaring is skipped while a still has
// bits above half width). After the last step come the final loop test, both
// squares and the output load. A bad root goes straight to the output load once
// the item is taken. With WIDTH = 64 the loop runs at most about 48 steps.
// Reset is asynchronous, active low, and clears the sequencer and out valid.
// A waiting result does not stop the next item being taken.
module sum_of_two_squares_from_root import sots_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sots_in_if.sink   in_i,
  sots_out_if.source out_o
);

  localparam int HALF = (WIDTH + 1) / 2;
  localparam int SQW  = 2 * HALF;
  localparam int SUMW = SQW + 1;

  sots_state_e state_q, state_d;

  logic [WIDTH-1:0]  p_q, p_d;
  logic [WIDTH-1:0]  a_q, a_d;
  logic [WIDTH-1:0]  b_q, b_d;
  logic [SQW-1:0]    sa_q, sa_d;
  logic              fail_q, fail_d;
  logic              out_valid_q, out_valid_d;
  logic [ROOT_W-1:0] fr_q, fr_d;
  logic [ROOT_W-1:0] sr_q, sr_d;
  logic              nf_q, nf_d;

  logic [WIDTH-1:0]  in_p;
  logic [WIDTH-1:0]  in_t;
  logic              in_ready;
  logic              do_step;
  logic              sq_en;
  logic [HALF-1:0]   sq_x;
  logic [SQW-1:0]    sq;
  logic              div_start;
  logic              div_done;
  logic [WIDTH-1:0]  div_rem;

  assign in_p = in_i.prime_value[WIDTH-1:0];
  assign in_t = in_i.root_of_minus_one[WIDTH-1:0];

  sots_square #(
    .HW (HALF)
  ) u_square (
    .clk_i (clk_i),
    .en_i  (sq_en),
    .x_i   (sq_x),
    .sq_o  (sq)
  );

  sots_divider #(
    .WIDTH (WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    a_d         = a_q;
    b_d         = b_q;
    sa_d        = sa_q;
    fail_d      = fail_q;
    out_valid_d = out_valid_q && !out_o.ready;
    fr_d        = fr_q;
    sr_d        = sr_q;
    nf_d        = nf_q;
    in_ready    = 1'b0;
    do_step     = 1'b0;
    sq_en       = 1'b0;
    sq_x        = a_q[HALF-1:0];
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          p_d = in_p;
          a_d = in_p;
          // divisor is the smaller of t and p - t
          b_d = (in_t > {1'b0, in_p[WIDTH-1:1]}) ? (in_p - in_t) : in_t;
          fail_d = (in_t == '0) || (in_t >= in_p);
          state_d = fail_d ? ST_OUT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        // upper half set means a*a already exceeds any p
        if (a_q[WIDTH-1:HALF] != '0) begin
          do_step = 1'b1;
        end else begin
          sq_en   = 1'b1;
          state_d = ST_CHECK_W;
        end
      end
      ST_CHECK_W: begin
        if (sq >= SQW'(p_q)) begin
          do_step = 1'b1;
        end else begin
          sq_en   = 1'b1;
          state_d = ST_FIN_A;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          a_d     = b_q;
          b_d     = div_rem;
          state_d = ST_CHECK;
        end
      end
      ST_FIN_A: begin
        sa_d    = sq;
        sq_en   = 1'b1;
        sq_x    = b_q[HALF-1:0];
        state_d = ST_FIN_B;
      end
      ST_FIN_B: begin
        fail_d  = (SUMW'(sa_q) + SUMW'(sq)) != SUMW'(p_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          fr_d        = fail_q ? '0 : ROOT_W'(a_q[HALF-1:0]);
          sr_d        = fail_q ? '0 : ROOT_W'(b_q[HALF-1:0]);
          nf_d        = fail_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_step) begin
      if (b_q == '0) begin
        fail_d  = 1'b1;
        state_d = ST_OUT;
      end else begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    a_q    <= a_d;
    b_q    <= b_d;
    sa_q   <= sa_d;
    fail_q <= fail_d;
    fr_q   <= fr_d;
    sr_q   <= sr_d;
    nf_q   <= nf_d;
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.first_root  = fr_q;
  assign out_o.second_root = sr_q;
  assign out_o.not_found   = nf_q;

endmodule
